// ===== src/seven_segment_animation_driver_defines.svh =====
// Assertion macros shared by the display driver checker.
// Needs a clock named clk and an active-low reset named arst_n in scope.
`ifndef SEVEN_SEGMENT_ANIMATION_DRIVER_DEFINES_SVH
`define SEVEN_SEGMENT_ANIMATION_DRIVER_DEFINES_SVH

// same-cycle implication
`define SSAD_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SSAD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/ssad_pkg.sv =====
// Types, register indexes and lookup tables for the seven-segment animation driver.
// No dependencies.
package ssad_pkg;

	typedef logic [4:0] symbol_t;

	localparam symbol_t     SYM_BLANK   = 5'd16;
	localparam logic [4:0]  SYM_LAST    = 5'd26;
	localparam logic [3:0]  SEQ_LEN     = 4'd12;
	localparam logic [9:0]  COUNT_MAX   = 10'd1023;
	localparam logic [9:0]  IDLE_RST    = 10'd80;
	localparam logic [9:0]  BLINK_RST   = 10'd350;
	localparam logic [9:0]  SCROLL_RST  = 10'd650;
	localparam int          TDATA_OUT_W = 72;
	localparam int          TDATA_IN_W  = 8;

	typedef enum logic [1:0] {
		MODE_OFF    = 2'd0,
		MODE_IDLE   = 2'd1,
		MODE_BLINK  = 2'd2,
		MODE_SCROLL = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		REG_DISPLAY_MODE  = 3'd0,
		REG_BLINK_TEXT    = 3'd1,
		REG_SCROLL_WORD   = 3'd2,
		REG_IDLE_PERIOD   = 3'd3,
		REG_BLINK_PERIOD  = 3'd4,
		REG_SCROLL_PERIOD = 3'd5
	} reg_index_t;

	// digit_index sits in the lowest bits
	typedef struct packed {
		logic [31:0] digit_word;
		logic [31:0] segment_word;
		symbol_t     symbol_code;
		logic [1:0]  digit_index;
	} result_t;

	function automatic logic [31:0] seg_word(input symbol_t sym);
		logic [31:0] w;
		case (sym)
			5'd0:  w = 32'd1610614752;
			5'd1:  w = 32'd1730150592;
			5'd2:  w = 32'd1149248352;
			5'd3:  w = 32'd1174413792;
			5'd4:  w = 32'd1126180032;
			5'd5:  w = 32'd1111500192;
			5'd6:  w = 32'd1077946272;
			5'd7:  w = 32'd1728053472;
			5'd8:  w = 32'd1073752032;
			5'd9:  w = 32'd1107305952;
			5'd10: w = 32'd1090528992;
			5'd11: w = 32'd1080043392;
			5'd12: w = 32'd1623197472;
			5'd13: w = 32'd1142956992;
			5'd14: w = 32'd1086334752;
			5'd15: w = 32'd1103111712;
			5'd16: w = 32'd1742733312;
			5'd17: w = 32'd1740636192;
			5'd18: w = 32'd1205870592;
			5'd19: w = 32'd1725956352;
			5'd20: w = 32'd1738539072;
			5'd21: w = 32'd1734344832;
			5'd22: w = 32'd1675625472;
			5'd23: w = 32'd1709179392;
			5'd24: w = 32'd1163928192;
			5'd25: w = 32'd1612711872;
			5'd26: w = 32'd1077946272;
			default: w = 32'd1742733312;
		endcase
		return w;
	endfunction

	function automatic logic [31:0] dig_word(input logic [1:0] pos);
		logic [31:0] w;
		case (pos)
			2'd0: w = 32'd65550;
			2'd1: w = 32'd131085;
			2'd2: w = 32'd262155;
			default: w = 32'd524295;
		endcase
		return w;
	endfunction

	function automatic symbol_t chase_sym(input logic [3:0] step);
		symbol_t s;
		case (step)
			4'd0, 4'd1, 4'd2, 4'd3:  s = 5'd17;
			4'd4:                    s = 5'd20;
			4'd5:                    s = 5'd21;
			4'd6, 4'd7, 4'd8, 4'd9:  s = 5'd19;
			4'd10:                   s = 5'd23;
			4'd11:                   s = 5'd22;
			default:                 s = SYM_BLANK;
		endcase
		return s;
	endfunction

	function automatic logic [1:0] chase_pos(input logic [3:0] step);
		logic [1:0] p;
		case (step)
			4'd0, 4'd9, 4'd10, 4'd11: p = 2'd0;
			4'd1, 4'd8:               p = 2'd1;
			4'd2, 4'd7:               p = 2'd2;
			default:                  p = 2'd3;
		endcase
		return p;
	endfunction

	function automatic symbol_t text_sym(input logic [2:0] text, input logic [1:0] pos);
		symbol_t s;
		case ({text, pos})
			5'b001_00: s = 5'd25;
			5'b001_01: s = 5'd1;
			5'b001_10: s = 5'd13;
			5'b010_00: s = 5'd26;
			5'b010_01: s = 5'd10;
			5'b010_10: s = 5'd13;
			5'b010_11: s = 5'd1;
			5'b011_00: s = 5'd13;
			5'b011_01: s = 5'd10;
			5'b011_10: s = 5'd24;
			5'b100_00: s = 5'd14;
			5'b100_01: s = 5'd24;
			5'b100_10: s = 5'd24;
			default:   s = SYM_BLANK;
		endcase
		return s;
	endfunction

	// blank, blank, blank, nibbles msb first, blank
	function automatic symbol_t scroll_sym(input logic [31:0] word, input logic [3:0] idx);
		symbol_t s;
		case (idx)
			4'd3:  s = {1'b0, word[31:28]};
			4'd4:  s = {1'b0, word[27:24]};
			4'd5:  s = {1'b0, word[23:20]};
			4'd6:  s = {1'b0, word[19:16]};
			4'd7:  s = {1'b0, word[15:12]};
			4'd8:  s = {1'b0, word[11:8]};
			4'd9:  s = {1'b0, word[7:4]};
			4'd10: s = {1'b0, word[3:0]};
			default: s = SYM_BLANK;
		endcase
		return s;
	endfunction

endpackage

// ===== src/seven_segment_animation_driver.sv =====
// An accepted tick passes the input register, then the result register. Throughput:
// one tick per cycle unless the result stream stalls; the input register and the result
// register part the two sides, so a stalled result holds only while the next tick is
// already registered. Ticks of zero give no result. Reset: blank digits, refresh position,
// counters and phases at zero, mode off, periods 80, 350 and 650 ms.
module seven_segment_animation_driver (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [ssad_pkg::TDATA_IN_W-1:0]   s_tdata,  // [0] tick, rest zero
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [ssad_pkg::TDATA_OUT_W-1:0]  m_tdata,  // digit_index, symbol_code,
	                                                    // segment_word, digit_word, pad
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [2:0]                        cfg_index,
	input  logic [31:0]                       cfg_data
);
	import ssad_pkg::*;

	logic        valid_s1, tick_s1;
	logic        valid_s2;
	result_t     result_s2;
	logic        advance, emit;

	mode_t       mode_q;
	logic [2:0]  blink_text_q;
	logic [31:0] scroll_word_q;
	logic [9:0]  idle_period_q, blink_period_q, scroll_period_q;
	symbol_t     shown_q [4];
	logic [1:0]  refresh_q;
	logic [9:0]  elapsed_q;
	logic [3:0]  chase_q;
	logic        phase_q;
	logic [3:0]  scroll_q;

	symbol_t     shown_next [4];
	logic [9:0]  elapsed_inc, elapsed_next, period;
	logic        fire;
	logic [3:0]  chase_s, scroll_s, chase_next, scroll_next, idx;
	logic        phase_next;
	symbol_t     sym;
	result_t     result_next;

	assign advance   = valid_s1 && (!tick_s1 || !valid_s2 || m_tready);
	assign emit      = advance && tick_s1;
	assign s_tready  = !valid_s1 || advance;
	assign m_tvalid  = valid_s2;
	assign m_tdata   = {{(TDATA_OUT_W - $bits(result_t)){1'b0}}, result_s2};
	assign cfg_ready = 1'b1;

	always_comb begin
		elapsed_inc = (elapsed_q == COUNT_MAX) ? elapsed_q : elapsed_q + 10'd1;
		case (mode_q)
			MODE_IDLE:   period = idle_period_q;
			MODE_BLINK:  period = blink_period_q;
			MODE_SCROLL: period = scroll_period_q;
			default:     period = COUNT_MAX;
		endcase
		fire         = (mode_q != MODE_OFF) && (elapsed_inc >= period);
		elapsed_next = fire ? 10'd0 : elapsed_inc;

		chase_s     = (chase_q >= SEQ_LEN) ? chase_q - SEQ_LEN : chase_q;
		scroll_s    = (scroll_q >= SEQ_LEN) ? scroll_q - SEQ_LEN : scroll_q;
		chase_next  = (chase_s == SEQ_LEN - 4'd1) ? 4'd0 : chase_s + 4'd1;
		scroll_next = (scroll_s == SEQ_LEN - 4'd1) ? 4'd0 : scroll_s + 4'd1;
		phase_next  = !phase_q;

		for (int i = 0; i < 4; i++) begin
			shown_next[i] = shown_q[i];
			idx = scroll_s + 4'(i);
			if (idx >= SEQ_LEN)
				idx = idx - SEQ_LEN;
			if (fire) begin
				case (mode_q)
					MODE_IDLE:   shown_next[i] = (2'(i) == chase_pos(chase_s)) ?
					                             chase_sym(chase_s) : SYM_BLANK;
					MODE_BLINK:  shown_next[i] = phase_q ?
					                             text_sym(blink_text_q, 2'(i)) : SYM_BLANK;
					MODE_SCROLL: shown_next[i] = scroll_sym(scroll_word_q, idx);
					default:     shown_next[i] = shown_q[i];
				endcase
			end
		end

		sym = shown_next[refresh_q];
		if (sym > SYM_LAST)
			sym = SYM_BLANK;
		result_next.digit_index  = refresh_q;
		result_next.symbol_code  = sym;
		result_next.segment_word = seg_word(sym);
		result_next.digit_word   = dig_word(refresh_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid)
			tick_s1 <= s_tdata[0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (emit) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit)
			result_s2 <= result_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q          <= MODE_OFF;
			blink_text_q    <= 3'd0;
			scroll_word_q   <= 32'd0;
			idle_period_q   <= IDLE_RST;
			blink_period_q  <= BLINK_RST;
			scroll_period_q <= SCROLL_RST;
			for (int i = 0; i < 4; i++)
				shown_q[i] <= SYM_BLANK;
			refresh_q <= 2'd0;
			elapsed_q <= 10'd0;
			chase_q   <= 4'd0;
			phase_q   <= 1'b0;
			scroll_q  <= 4'd0;
		end else begin
			if (emit) begin
				shown_q   <= shown_next;
				refresh_q <= refresh_q + 2'd1;
				elapsed_q <= elapsed_next;
				if (fire) begin
					case (mode_q)
						MODE_IDLE:   chase_q  <= chase_next;
						MODE_BLINK:  phase_q  <= phase_next;
						MODE_SCROLL: scroll_q <= scroll_next;
						default:     chase_q  <= chase_q;
					endcase
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (reg_index_t'(cfg_index))
					REG_DISPLAY_MODE: begin
						mode_q    <= mode_t'(cfg_data[1:0]);
						elapsed_q <= 10'd0;
					end
					REG_BLINK_TEXT: begin
						blink_text_q <= cfg_data[2:0];
						phase_q      <= 1'b0;
					end
					REG_SCROLL_WORD: begin
						scroll_word_q <= cfg_data;
						scroll_q      <= 4'd0;
					end
					REG_IDLE_PERIOD:   idle_period_q   <= cfg_data[9:0];
					REG_BLINK_PERIOD:  blink_period_q  <= cfg_data[9:0];
					REG_SCROLL_PERIOD: scroll_period_q <= cfg_data[9:0];
					default:           mode_q          <= mode_q;
				endcase
			end
		end
	end

endmodule

// ===== src/ssad_checker.sv =====
// Port-level checks for the seven-segment animation driver, bound to the top level.
// Depends on ssad_pkg and seven_segment_animation_driver_defines.svh.
`include "seven_segment_animation_driver_defines.svh"

module ssad_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             s_tready,
	input logic                             m_tvalid,
	input logic                             m_tready,
	input logic [ssad_pkg::TDATA_OUT_W-1:0] m_tdata
);
	import ssad_pkg::*;

	`SSAD_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled result transaction changed")
	`SSAD_ASSERT_NOW(a_ready_when_empty, !m_tvalid, s_tready, "input stalled with empty result register")
	`SSAD_ASSERT_NOW(a_symbol_range, m_tvalid, m_tdata[6:2] <= SYM_LAST, "symbol code out of range")
	`SSAD_ASSERT_NOW(a_segment_match, m_tvalid, m_tdata[38:7] == seg_word(m_tdata[6:2]), "segment word does not match symbol")
	`SSAD_ASSERT_NOW(a_digit_match, m_tvalid, m_tdata[70:39] == dig_word(m_tdata[1:0]), "digit word does not match digit index")

endmodule

bind seven_segment_animation_driver ssad_checker u_ssad_checker (.*);

// ===== bench/ssad_display_checker.sv =====
// Scoreboard for the seven-segment animation driver: follows the config writes and the
// accepted ticks, predicts each refresh transaction and compares it with the result stream.
// Depends on ssad_pkg for the port widths, register indexes, modes and the result layout.
module ssad_display_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	input  logic                              s_tready,
	input  logic [ssad_pkg::TDATA_IN_W-1:0]   s_tdata,  // [0] tick, rest zero
	input  logic                              m_tvalid,
	input  logic                              m_tready,
	input  logic [ssad_pkg::TDATA_OUT_W-1:0]  m_tdata,  // digit_index, symbol_code,
	                                                    // segment_word, digit_word, pad
	input  logic                              cfg_valid,
	input  logic                              cfg_ready,
	input  logic [2:0]                        cfg_index,
	input  logic [31:0]                       cfg_data,
	output int                                mismatches,
	output int                                scans_due
);
	import ssad_pkg::*;

	logic [31:0] glyph_segments [27] = '{
		32'd1610614752, 32'd1730150592, 32'd1149248352, 32'd1174413792, 32'd1126180032,
		32'd1111500192, 32'd1077946272, 32'd1728053472, 32'd1073752032, 32'd1107305952,
		32'd1090528992, 32'd1080043392, 32'd1623197472, 32'd1142956992, 32'd1086334752,
		32'd1103111712, 32'd1742733312, 32'd1740636192, 32'd1205870592, 32'd1725956352,
		32'd1738539072, 32'd1734344832, 32'd1675625472, 32'd1709179392, 32'd1163928192,
		32'd1612711872, 32'd1077946272};
	logic [31:0] digit_select [4] = '{32'd65550, 32'd131085, 32'd262155, 32'd524295};
	logic [4:0]  chase_glyph [12] = '{5'd17, 5'd17, 5'd17, 5'd17, 5'd20, 5'd21,
		5'd19, 5'd19, 5'd19, 5'd19, 5'd23, 5'd22};
	logic [1:0]  chase_digit [12] = '{2'd0, 2'd1, 2'd2, 2'd3, 2'd3, 2'd3,
		2'd3, 2'd2, 2'd1, 2'd0, 2'd0, 2'd0};
	// indexed by {text, digit}
	logic [4:0]  text_glyph [32] = '{
		5'd16, 5'd16, 5'd16, 5'd16,  5'd25, 5'd1,  5'd13, 5'd16,
		5'd26, 5'd10, 5'd13, 5'd1,   5'd13, 5'd10, 5'd24, 5'd16,
		5'd14, 5'd24, 5'd24, 5'd16,  5'd16, 5'd16, 5'd16, 5'd16,
		5'd16, 5'd16, 5'd16, 5'd16,  5'd16, 5'd16, 5'd16, 5'd16};

	mode_t       mode;
	logic [2:0]  text;
	logic [31:0] scroll_value;
	logic [9:0]  idle_ms, blink_ms, scroll_ms;
	logic [4:0]  shown [4];
	logic [1:0]  refresh_pos;
	logic [9:0]  elapsed;
	logic [3:0]  chase, scroll_pos;
	logic        blink_on;
	result_t     expected_scans [$];

	always @(posedge clk or negedge arst_n) begin : track
		result_t    due, got;
		logic [9:0] period;
		logic [3:0] idx;
		if (!arst_n) begin
			mode = MODE_OFF;
			text = '0;
			scroll_value = '0;
			idle_ms = IDLE_RST;
			blink_ms = BLINK_RST;
			scroll_ms = SCROLL_RST;
			for (int i = 0; i < 4; i++)
				shown[i] = SYM_BLANK;
			refresh_pos = '0;
			elapsed = '0;
			chase = '0;
			blink_on = 1'b0;
			scroll_pos = '0;
			expected_scans.delete();
			mismatches = 0;
			scans_due = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (reg_index_t'(cfg_index))
					REG_DISPLAY_MODE: begin
						mode = mode_t'(cfg_data[1:0]);
						elapsed = '0;
					end
					REG_BLINK_TEXT: begin
						text = cfg_data[2:0];
						blink_on = 1'b0;
					end
					REG_SCROLL_WORD: begin
						scroll_value = cfg_data;
						scroll_pos = '0;
					end
					REG_IDLE_PERIOD:   idle_ms = cfg_data[9:0];
					REG_BLINK_PERIOD:  blink_ms = cfg_data[9:0];
					REG_SCROLL_PERIOD: scroll_ms = cfg_data[9:0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready && s_tdata[0]) begin
				if (elapsed != COUNT_MAX)
					elapsed = elapsed + 10'd1;
				case (mode)
					MODE_IDLE:  period = idle_ms;
					MODE_BLINK: period = blink_ms;
					default:    period = scroll_ms;
				endcase
				if (mode != MODE_OFF && elapsed >= period) begin
					elapsed = '0;
					case (mode)
						MODE_IDLE: begin
							for (int i = 0; i < 4; i++)
								shown[i] = (2'(i) == chase_digit[chase]) ?
									chase_glyph[chase] : SYM_BLANK;
							chase = (chase == SEQ_LEN - 4'd1) ? 4'd0 : chase + 4'd1;
						end
						MODE_BLINK: begin
							for (int i = 0; i < 4; i++)
								shown[i] = blink_on ? text_glyph[{text, 2'(i)}] : SYM_BLANK;
							blink_on = !blink_on;
						end
						default: begin
							for (int i = 0; i < 4; i++) begin
								idx = 4'((int'(scroll_pos) + i) % 12);
								if (idx < 4'd3 || idx > 4'd10)
									shown[i] = SYM_BLANK;
								else
									shown[i] = {1'b0,
										4'(scroll_value >> (4 * (10 - int'(idx))))};
							end
							scroll_pos = (scroll_pos == SEQ_LEN - 4'd1) ? 4'd0 : scroll_pos + 4'd1;
						end
					endcase
				end
				due.digit_index = refresh_pos;
				due.symbol_code = (shown[refresh_pos] > SYM_LAST) ? SYM_BLANK : shown[refresh_pos];
				due.segment_word = glyph_segments[due.symbol_code];
				due.digit_word = digit_select[refresh_pos];
				expected_scans.push_back(due);
				refresh_pos = refresh_pos + 2'd1;
			end
			if (m_tvalid && m_tready) begin
				got = m_tdata[$bits(result_t)-1:0];
				if (expected_scans.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected scan: digit %0d symbol %0d segments %h digits %h",
							got.digit_index, got.symbol_code, got.segment_word, got.digit_word);
				end else begin
					due = expected_scans.pop_front();
					if (got.digit_index !== due.digit_index || got.symbol_code !== due.symbol_code ||
						got.segment_word !== due.segment_word || got.digit_word !== due.digit_word) begin
						mismatches++;
						if (mismatches <= 10)
							$display("scan mismatch: expected %0d/%0d/%h/%h, got %0d/%0d/%h/%h",
								due.digit_index, due.symbol_code, due.segment_word, due.digit_word,
								got.digit_index, got.symbol_code, got.segment_word, got.digit_word);
					end
				end
			end
			scans_due = expected_scans.size();
		end
	end

endmodule

// ===== bench/tb_seven_segment_animation_driver.sv =====
// Top of the seven-segment animation driver bench: clock, reset, tick and config stimulus,
// random back-pressure on the result stream and the final verdict.
// Depends on ssad_pkg, seven_segment_animation_driver and ssad_display_checker.
module tb_seven_segment_animation_driver;
	import ssad_pkg::*;

	localparam int RUN_LIMIT   = 1000000;
	localparam int LONG_HOLD   = 300;
	localparam int TICK_TARGET = 1000;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [TDATA_IN_W-1:0]  s_tdata = '0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [TDATA_OUT_W-1:0] m_tdata;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [2:0]             cfg_index = '0;
	logic [31:0]            cfg_data = '0;
	int                     mismatches, scans_due;
	int                     cycle_count = 0;
	int                     ticks_sent = 0;
	bit                     hold_request = 1'b0;
	bit                     steady = 1'b0;

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	seven_segment_animation_driver i_dut (.*);

	ssad_display_checker i_checker (.*);

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(25, 70);
	endfunction

	function automatic logic [31:0] pick_period();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return $urandom_range(0, 4);
		if (r < 80)
			return $urandom_range(5, 40);
		if (r < 88)
			return 32'd0;
		if (r < 94)
			return 32'd1023;
		return $urandom;
	endfunction

	task automatic send_tick(input logic tick_bit);
		int gap;
		gap = steady ? 0 : pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {{(TDATA_IN_W-1){1'b0}}, tick_bit};
		do @(posedge clk); while (!s_tready);
		if (tick_bit)
			ticks_sent++;
	endtask

	// leaves cfg_valid high; the caller drops it after the last write
	task automatic write_reg(input reg_index_t idx, input logic [31:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (scans_due != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > RUN_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin : receiver
		bit held;
		int span;
		held = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_request && !held) begin
				m_tready <= 1'b0;
				held = 1'b1;
				repeat (LONG_HOLD) @(posedge clk);
			end else begin
				if ($urandom_range(0, 9) < 6) begin
					m_tready <= 1'b1;
					span = $urandom_range(1, 24);
				end else begin
					m_tready <= 1'b0;
					span = pick_gap() + 1;
				end
				for (int k = 0; k < span && !(hold_request && !held); k++)
					@(posedge clk);
			end
		end
	end

	initial begin : stimulus
		int  phase, count;
		bit  wrote;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// off mode: digits stay blank, a zero tick gives nothing
		send_tick(1'b1);
		send_tick(1'b0);
		send_tick(1'b1);
		send_tick(1'b1);
		settle();
		// chase on every tick, wrapping the sequence
		write_reg(REG_IDLE_PERIOD, 32'd0);
		write_reg(REG_DISPLAY_MODE, MODE_IDLE);
		cfg_valid <= 1'b0;
		repeat (13) send_tick(1'b1);
		settle();
		write_reg(REG_SCROLL_WORD, 32'hFFFF_FFFF);
		write_reg(REG_SCROLL_PERIOD, 32'd1023);
		write_reg(REG_DISPLAY_MODE, MODE_SCROLL);
		cfg_valid <= 1'b0;
		repeat (2) send_tick(1'b1);
		settle();
		write_reg(REG_BLINK_TEXT, 32'd4);
		write_reg(REG_BLINK_PERIOD, 32'd1);
		write_reg(REG_DISPLAY_MODE, MODE_BLINK);
		cfg_valid <= 1'b0;
		repeat (4) send_tick(1'b1);

		phase = 0;
		while (ticks_sent < TICK_TARGET) begin
			settle();
			wrote = 1'b0;
			if ($urandom_range(0, 1)) begin
				write_reg(REG_SCROLL_WORD, ($urandom_range(0, 3) == 0) ? 32'd0 :
					($urandom_range(0, 2) == 0) ? 32'hFFFF_FFFF : $urandom);
				wrote = 1'b1;
			end
			if ($urandom_range(0, 1)) begin
				write_reg(REG_BLINK_TEXT, $urandom_range(0, 7));
				wrote = 1'b1;
			end
			if ($urandom_range(0, 2) == 0) begin
				write_reg(REG_IDLE_PERIOD, pick_period());
				wrote = 1'b1;
			end
			if ($urandom_range(0, 2) == 0) begin
				write_reg(REG_BLINK_PERIOD, pick_period());
				wrote = 1'b1;
			end
			if ($urandom_range(0, 2) == 0) begin
				write_reg(REG_SCROLL_PERIOD, pick_period());
				wrote = 1'b1;
			end
			if ($urandom_range(0, 1)) begin
				write_reg(REG_DISPLAY_MODE, $urandom_range(MODE_OFF, MODE_SCROLL));
				wrote = 1'b1;
			end
			if (wrote)
				cfg_valid <= 1'b0;
			steady = ($urandom_range(0, 3) == 0);
			count = $urandom_range(10, 60);
			// stall the result side for a long stretch while ticks keep coming
			if (phase == 3) begin
				hold_request = 1'b1;
				steady = 1'b1;
				count = 80;
			end
			repeat (count) send_tick($urandom_range(0, 9) != 0);
			phase++;
		end
		steady = 1'b0;
		settle();
		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
